[rtl/ray_sphere_intersect_macros.svh]
// Assertion macros used by the assertion checker file.
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RSI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ray_sphere_intersect check failed");

// Consequent checked in the cycle after the antecedent.
`define RSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ray_sphere_intersect check failed");

// Consequent checked in the cycle after reset is seen.
`define RSI_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("ray_sphere_intersect reset check failed");

`endif

[rtl/rsi_pkg.sv]
package rsi_pkg;

   localparam int COORD_W    = 32;
   localparam int DIST_W     = 31;
   localparam int COLOR_W    = 24;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // one root bit per pair of discriminant bits
   localparam int SQRT_STEPS = 66;
   localparam int DIV_STEPS  = DIST_W;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [DIST_W-1:0]         dist_type;
   typedef logic [COLOR_W-1:0]        color_type;

   localparam color_type COLOR_RESET    = 24'hFF_FFFF;
   localparam dist_type  MIN_DIST_RESET = 31'd66;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTRE_X      = 3'd0,
      CSR_CENTRE_Y      = 3'd1,
      CSR_CENTRE_Z      = 3'd2,
      CSR_SPHERE_RADIUS = 3'd3,
      CSR_SURFACE_COLOR = 3'd4,
      CSR_MIN_DISTANCE  = 3'd5
   } csr_index_type;

endpackage

[rtl/rsi_req_if.sv]
interface rsi_req_if;
   logic                valid;
   logic                ready;
   rsi_pkg::coord_type  origin_x;
   rsi_pkg::coord_type  origin_y;
   rsi_pkg::coord_type  origin_z;
   rsi_pkg::coord_type  dir_x;
   rsi_pkg::coord_type  dir_y;
   rsi_pkg::coord_type  dir_z;
   rsi_pkg::dist_type   nearest_so_far;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   nearest_so_far, input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 nearest_so_far, output ready);
endinterface

[rtl/rsi_rsp_if.sv]
interface rsi_rsp_if;
   logic                valid;
   logic                ready;
   logic                hit;
   rsi_pkg::dist_type   hit_distance;
   rsi_pkg::color_type  hit_color;

   modport source (output valid, hit, hit_distance, hit_color, input ready);
   modport sink (input valid, hit, hit_distance, hit_color, output ready);
endinterface

[rtl/ray_sphere_intersect.sv]
// Ray against sphere test, one ray per item, one result item per ray.
// Throughput one item per cycle while the result is not held. Depth comes from
// the 66-stage square root and the 31-stage dual-lane divider. The whole pipe
// stalls together when the result is held.
// Reset (synchronous) clears all valid bits and loads the register defaults.
module ray_sphere_intersect #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   rsi_req_if.sink                             req_ch,
   rsi_rsp_if.source                           rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [rsi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rsi_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam int CW   = rsi_pkg::COORD_W;
   localparam int LW   = rsi_pkg::DIST_W;
   localparam int OW   = CW + 1;
   localparam int PDDW = 2 * CW;
   localparam int PDOW = CW + OW;
   localparam int POOW = 2 * OW;
   localparam int PRRW = 2 * LW;
   localparam int AW   = 2 * CW;
   localparam int HW   = PDOW + 1;
   localparam int C3W  = POOW + 1;
   localparam int HMW  = HW - 1;
   localparam int CMW  = C3W - 1;
   localparam int LOW  = 33;
   localparam int AHALF = AW / 2;
   localparam int HHW  = 130;
   localparam int ACW  = 130;
   localparam int SS   = rsi_pkg::SQRT_STEPS;
   localparam int DW   = 2 * SS;
   localparam int QW   = SS;
   localparam int SRW  = SS + 2;
   localparam int NW   = HW + 2;
   localparam int XW   = NW + FRAC_BITS;
   localparam int DS   = rsi_pkg::DIV_STEPS;
   localparam int QSW  = AW + DS;
   localparam int RW   = ((XW > QSW) ? XW : QSW) + 1;

   // configuration registers
   rsi_pkg::coord_type centre_ff [0:2];
   rsi_pkg::dist_type  radius_ff;
   rsi_pkg::color_type color_ff;
   rsi_pkg::dist_type  min_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_ff[0] <= '0;
         centre_ff[1] <= '0;
         centre_ff[2] <= '0;
         radius_ff    <= rsi_pkg::dist_type'(1) << FRAC_BITS;
         color_ff     <= rsi_pkg::COLOR_RESET;
         min_dist_ff  <= rsi_pkg::MIN_DIST_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            rsi_pkg::CSR_CENTRE_X:      centre_ff[0] <= csr_wr_data;
            rsi_pkg::CSR_CENTRE_Y:      centre_ff[1] <= csr_wr_data;
            rsi_pkg::CSR_CENTRE_Z:      centre_ff[2] <= csr_wr_data;
            rsi_pkg::CSR_SPHERE_RADIUS: radius_ff <= csr_wr_data[LW-1:0];
            rsi_pkg::CSR_SURFACE_COLOR: color_ff <= csr_wr_data[rsi_pkg::COLOR_W-1:0];
            rsi_pkg::CSR_MIN_DISTANCE:  min_dist_ff <= csr_wr_data[LW-1:0];
            default: ;
         endcase
      end
   end

   logic out_v_ff;
   logic adv;

   // the whole pipe moves together; hold everything while the result waits
   assign adv          = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // stage 1: origin into sphere space
   logic                   v1_ff;
   logic signed [OW-1:0]   o1_ff [0:2];
   logic signed [CW-1:0]   d1_ff [0:2];
   rsi_pkg::dist_type      near1_ff;
   logic signed [OW-1:0]   o1_in [0:2];

   always_comb begin
      o1_in[0] = OW'(req_ch.origin_x) - OW'(centre_ff[0]);
      o1_in[1] = OW'(req_ch.origin_y) - OW'(centre_ff[1]);
      o1_in[2] = OW'(req_ch.origin_z) - OW'(centre_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o1_ff    <= o1_in;
         d1_ff[0] <= req_ch.dir_x;
         d1_ff[1] <= req_ch.dir_y;
         d1_ff[2] <= req_ch.dir_z;
         near1_ff <= req_ch.nearest_so_far;
      end
   end

   // stage 2: dot product terms
   logic                   v2_ff;
   logic signed [PDDW-1:0] pdd2_ff [0:2];
   logic signed [PDOW-1:0] pdo2_ff [0:2];
   logic signed [POOW-1:0] poo2_ff [0:2];
   logic [PRRW-1:0]        prr2_ff;
   logic signed [HW-1:0]   dummy_unused_guard;
   rsi_pkg::dist_type      near2_ff;

   assign dummy_unused_guard = '0;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pdd2_ff[i] <= d1_ff[i] * d1_ff[i];
            pdo2_ff[i] <= d1_ff[i] * o1_ff[i];
            poo2_ff[i] <= o1_ff[i] * o1_ff[i];
         end
         prr2_ff  <= radius_ff * radius_ff;
         near2_ff <= near1_ff;
      end
   end

   // stage 3: A, H, C
   logic                   v3_ff;
   logic [AW-1:0]          a3_ff;
   logic signed [HW-1:0]   h3_ff;
   logic signed [C3W-1:0]  c3_ff;
   rsi_pkg::dist_type      near3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a3_ff <= AW'(pdd2_ff[0]) + AW'(pdd2_ff[1]) + AW'(pdd2_ff[2]);
         h3_ff <= HW'(pdo2_ff[0]) + HW'(pdo2_ff[1]) + HW'(pdo2_ff[2]) + dummy_unused_guard;
         c3_ff <= C3W'(poo2_ff[0]) + C3W'(poo2_ff[1]) + C3W'(poo2_ff[2])
                  - C3W'($signed({1'b0, prr2_ff}));
         near3_ff <= near2_ff;
      end
   end

   // stage 4: partial products of H*H and A*|C|
   logic                   v4_ff;
   logic [HMW-1:0]         habs;
   logic [CMW-1:0]         cabs;
   logic [2*LOW-1:0]       p_hll4_ff;
   logic [HMW-1:0]         p_hlh4_ff;
   logic [2*(HMW-LOW)-1:0] p_hhh4_ff;
   logic [AHALF+LOW-1:0]   p_acll4_ff;
   logic [AHALF+LOW-1:0]   p_aclh4_ff;
   logic [AHALF+LOW-1:0]   p_achl4_ff;
   logic [AHALF+LOW-1:0]   p_achh4_ff;
   logic                   cneg4_ff;
   logic                   azero4_ff;
   logic [AW-1:0]          a4_ff;
   logic signed [HW-1:0]   h4_ff;
   rsi_pkg::dist_type      near4_ff;

   always_comb begin
      habs = h3_ff[HW-1] ? HMW'(-h3_ff) : HMW'(h3_ff);
      cabs = c3_ff[C3W-1] ? CMW'(-c3_ff) : CMW'(c3_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_hll4_ff  <= habs[LOW-1:0] * habs[LOW-1:0];
         p_hlh4_ff  <= habs[LOW-1:0] * habs[HMW-1:LOW];
         p_hhh4_ff  <= habs[HMW-1:LOW] * habs[HMW-1:LOW];
         p_acll4_ff <= a3_ff[AHALF-1:0] * cabs[LOW-1:0];
         p_aclh4_ff <= a3_ff[AHALF-1:0] * cabs[CMW-1:LOW];
         p_achl4_ff <= a3_ff[AW-1:AHALF] * cabs[LOW-1:0];
         p_achh4_ff <= a3_ff[AW-1:AHALF] * cabs[CMW-1:LOW];
         cneg4_ff   <= c3_ff[C3W-1];
         azero4_ff  <= (a3_ff == '0);
         a4_ff      <= a3_ff;
         h4_ff      <= h3_ff;
         near4_ff   <= near3_ff;
      end
   end

   // stage 5: assemble H*H and A*|C|
   logic                   v5_ff;
   logic [HHW-1:0]         hh5_ff;
   logic [ACW-1:0]         ac5_ff;
   logic                   cneg5_ff;
   logic                   azero5_ff;
   logic [AW-1:0]          a5_ff;
   logic signed [HW-1:0]   h5_ff;
   rsi_pkg::dist_type      near5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         hh5_ff <= HHW'(p_hll4_ff) + (HHW'(p_hlh4_ff) << (LOW + 1))
                   + (HHW'(p_hhh4_ff) << (2 * LOW));
         ac5_ff <= ACW'(p_acll4_ff) + (ACW'(p_aclh4_ff) << LOW)
                   + (ACW'(p_achl4_ff) << AHALF) + (ACW'(p_achh4_ff) << (AHALF + LOW));
         cneg5_ff  <= cneg4_ff;
         azero5_ff <= azero4_ff;
         a5_ff     <= a4_ff;
         h5_ff     <= h4_ff;
         near5_ff  <= near4_ff;
      end
   end

   // stage 6: discriminant, feeds the root pipe
   logic signed [DW-1:0]   dsum;

   always_comb begin
      if (cneg5_ff) begin
         dsum = $signed({2'b00, hh5_ff}) + $signed({2'b00, ac5_ff});
      end else begin
         dsum = $signed({2'b00, hh5_ff}) - $signed({2'b00, ac5_ff});
      end
   end

   logic                   sq_v_ff    [0:SS];
   logic [SRW-1:0]         sq_rem_ff  [0:SS];
   logic [QW-1:0]          sq_q_ff    [0:SS];
   logic [DW-1:0]          sq_d_ff    [0:SS];
   logic signed [HW-1:0]   sq_h_ff    [0:SS];
   logic [AW-1:0]          sq_a_ff    [0:SS];
   rsi_pkg::dist_type      sq_near_ff [0:SS];
   logic                   sq_miss_ff [0:SS];

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff[0]  <= '0;
         sq_q_ff[0]    <= '0;
         sq_d_ff[0]    <= dsum;
         sq_h_ff[0]    <= h5_ff;
         sq_a_ff[0]    <= a5_ff;
         sq_near_ff[0] <= near5_ff;
         sq_miss_ff[0] <= azero5_ff || dsum[DW-1];
      end
   end

   // valid bits of the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         v5_ff      <= 1'b0;
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         v1_ff      <= req_ch.valid;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         v4_ff      <= v3_ff;
         v5_ff      <= v4_ff;
         sq_v_ff[0] <= v5_ff;
      end
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < SS; k++) begin : g_sqrt
      logic [SRW+1:0] rs;
      logic [SRW+1:0] trial;
      logic           ge;

      always_comb begin
         rs    = {sq_rem_ff[k], sq_d_ff[k][DW-1:DW-2]};
         trial = {2'b00, sq_q_ff[k], 2'b01};
         ge    = (rs >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[k+1]  <= ge ? SRW'(rs - trial) : SRW'(rs);
            sq_q_ff[k+1]    <= {sq_q_ff[k][QW-2:0], ge};
            sq_d_ff[k+1]    <= sq_d_ff[k] << 2;
            sq_h_ff[k+1]    <= sq_h_ff[k];
            sq_a_ff[k+1]    <= sq_a_ff[k];
            sq_near_ff[k+1] <= sq_near_ff[k];
            sq_miss_ff[k+1] <= sq_miss_ff[k];
         end
      end
   end

   // root numerators, scaled; range checks ahead of the divider
   logic                   dv_v_ff    [0:DS];
   logic [RW-1:0]          dv_rem_ff  [0:DS][0:1];
   rsi_pkg::dist_type      dv_q_ff    [0:DS][0:1];
   logic                   dv_neg_ff  [0:DS][0:1];
   logic                   dv_big_ff  [0:DS][0:1];
   logic [AW-1:0]          dv_a_ff    [0:DS];
   rsi_pkg::dist_type      dv_near_ff [0:DS];
   logic                   dv_miss_ff [0:DS];

   logic signed [NW-1:0]   hx;
   logic signed [NW-1:0]   sx;
   logic signed [NW-1:0]   num   [0:1];
   logic signed [XW-1:0]   xs    [0:1];
   logic [RW-1:0]          xmag  [0:1];
   logic [RW-1:0]          alim;

   always_comb begin
      hx     = NW'(sq_h_ff[SS]);
      sx     = $signed({2'b00, sq_q_ff[SS]});
      num[0] = -hx - sx;
      num[1] = -hx + sx;
      alim   = RW'(sq_a_ff[SS]) << DS;
      for (int j = 0; j < 2; j++) begin
         xs[j]   = XW'(num[j]) <<< FRAC_BITS;
         xmag[j] = RW'(xs[j][XW-2:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= sq_v_ff[SS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 2; j++) begin
            dv_rem_ff[0][j] <= xmag[j];
            dv_q_ff[0][j]   <= '0;
            dv_neg_ff[0][j] <= xs[j][XW-1];
            dv_big_ff[0][j] <= (xmag[j] >= alim);
         end
         dv_a_ff[0]    <= sq_a_ff[SS];
         dv_near_ff[0] <= sq_near_ff[SS];
         dv_miss_ff[0] <= sq_miss_ff[SS];
      end
   end

   // restoring divide, both roots side by side, one quotient bit per stage
   for (genvar k = 0; k < DS; k++) begin : g_div
      localparam int B = DS - 1 - k;
      logic [RW-1:0] sd;
      logic          ge [0:1];

      always_comb begin
         sd = RW'(dv_a_ff[k]) << B;
         for (int j = 0; j < 2; j++) begin
            ge[j] = (dv_rem_ff[k][j] >= sd);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int j = 0; j < 2; j++) begin
               dv_rem_ff[k+1][j] <= ge[j] ? (dv_rem_ff[k][j] - sd) : dv_rem_ff[k][j];
               dv_q_ff[k+1][j]   <= dv_q_ff[k][j] | (LW'(ge[j]) << B);
               dv_neg_ff[k+1][j] <= dv_neg_ff[k][j];
               dv_big_ff[k+1][j] <= dv_big_ff[k][j];
            end
            dv_a_ff[k+1]    <= dv_a_ff[k];
            dv_near_ff[k+1] <= dv_near_ff[k];
            dv_miss_ff[k+1] <= dv_miss_ff[k];
         end
      end
   end

   // pick near root, else far root, else miss
   logic                 ok [0:1];
   logic                 hit_in;
   rsi_pkg::dist_type    dist_in;
   logic                 out_hit_ff;
   rsi_pkg::dist_type    out_dist_ff;
   rsi_pkg::color_type   out_color_ff;

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         ok[j] = !dv_miss_ff[DS] && !dv_neg_ff[DS][j] && !dv_big_ff[DS][j]
                 && (dv_q_ff[DS][j] > min_dist_ff) && (dv_q_ff[DS][j] < dv_near_ff[DS]);
      end
      hit_in = ok[0] || ok[1];
      if (ok[0]) begin
         dist_in = dv_q_ff[DS][0];
      end else if (ok[1]) begin
         dist_in = dv_q_ff[DS][1];
      end else begin
         dist_in = dv_near_ff[DS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_v_ff[DS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_hit_ff   <= hit_in;
         out_dist_ff  <= dist_in;
         out_color_ff <= hit_in ? color_ff : '0;
      end
   end

   assign rsp_ch.valid        = out_v_ff;
   assign rsp_ch.hit          = out_hit_ff;
   assign rsp_ch.hit_distance = out_dist_ff;
   assign rsp_ch.hit_color    = out_color_ff;

endmodule

[rtl/rsi_checker.sv]
`include "ray_sphere_intersect_macros.svh"

module rsi_assert_checker (
   input  logic        clock,
   input  logic        reset,
   rsi_rsp_if.source   rsp_ch
);

   logic                                        stalled;
   logic [rsi_pkg::DIST_W+rsi_pkg::COLOR_W:0]   payload;

   assign stalled = rsp_ch.valid && !rsp_ch.ready;
   assign payload = {rsp_ch.hit, rsp_ch.hit_distance, rsp_ch.hit_color};

   // result item stays offered until taken
   `RSI_ASSERT_NEXT(a_hold_valid, clock, reset, stalled, rsp_ch.valid)
   // stalled result item keeps its payload
   `RSI_ASSERT_NEXT(a_hold_data, clock, reset, stalled, $stable(payload))
   // a miss carries no colour, a hit has a nonzero distance
   `RSI_ASSERT_SAME(a_miss_color, clock, reset, (rsp_ch.valid && !rsp_ch.hit), (rsp_ch.hit_color == '0))
   `RSI_ASSERT_SAME(a_hit_dist, clock, reset, (rsp_ch.valid && rsp_ch.hit), (rsp_ch.hit_distance != '0))
   // pipe is empty after reset
   `RSI_ASSERT_AFTER_RESET(a_reset_empty, clock, reset, !rsp_ch.valid)

endmodule

bind ray_sphere_intersect rsi_assert_checker u_rsi_checker (
   .clock  (clock),
   .reset  (reset),
   .rsp_ch (rsp_ch)
);

[tb/sv/rsi_checker.sv]
`timescale 1ns / 100ps

module rsi_checker (
   input  logic                           clock,
   input  logic                           reset,
   rsi_req_if                             req,
   rsi_rsp_if                             rsp,
   input  logic                           csr_wr_en,
   input  logic [rsi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rsi_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output int                             fail_count,
   output int                             pending
);
   import rsi_pkg::*;

   typedef logic signed [255:0] wide_t;

   typedef struct packed {
      logic      hit;
      dist_type  distance;
      color_type color;
   } hit_record_t;

   coord_type   sphere_cx, sphere_cy, sphere_cz;
   dist_type    sphere_r, near_limit;
   color_type   sphere_color;
   hit_record_t expected_hits[$];
   int          errors;

   assign fail_count = errors;
   assign pending    = expected_hits.size();

   // floor division toward minus infinity, then window test
   function automatic bit root_in_window(input wide_t num, input wide_t a,
                                         input wide_t lo, input wide_t hi,
                                         output wide_t t);
      t = num / a;
      if (num % a != 0 && num < 0) t = t - 1;
      return t > lo && t < hi;
   endfunction

   function automatic hit_record_t intersect_sphere(
      input coord_type px, py, pz, vx, vy, vz, input dist_type limit);
      wide_t ox, oy, oz, dx, dy, dz, a, h, c, disc, sq, trial, t, lo, hi;
      hit_record_t rec;
      rec.hit      = 1'b0;
      rec.distance = limit;
      rec.color    = '0;
      ox = wide_t'(px) - wide_t'(sphere_cx);
      oy = wide_t'(py) - wide_t'(sphere_cy);
      oz = wide_t'(pz) - wide_t'(sphere_cz);
      dx = wide_t'(vx);
      dy = wide_t'(vy);
      dz = wide_t'(vz);
      a  = dx * dx + dy * dy + dz * dz;
      if (a == 0) return rec;
      h    = dx * ox + dy * oy + dz * oz;
      c    = ox * ox + oy * oy + oz * oz - wide_t'(sphere_r) * wide_t'(sphere_r);
      disc = h * h - a * c;
      if (disc < 0) return rec;
      sq = 0;
      for (int b = 69; b >= 0; b--) begin
         trial = sq | (wide_t'(1) << b);
         if (trial * trial <= disc) sq = trial;
      end
      lo = wide_t'(near_limit);
      hi = wide_t'(limit);
      // near root first, then far root
      if (!root_in_window((-h - sq) * wide_t'(1 << 16), a, lo, hi, t))
         if (!root_in_window((-h + sq) * wide_t'(1 << 16), a, lo, hi, t))
            return rec;
      rec.hit      = 1'b1;
      rec.distance = t[DIST_W-1:0];
      rec.color    = sphere_color;
      return rec;
   endfunction

   always @(posedge clock) begin
      hit_record_t got, want;
      if (reset) begin
         sphere_cx    <= '0;
         sphere_cy    <= '0;
         sphere_cz    <= '0;
         sphere_r     <= dist_type'(1 << 16);
         sphere_color <= COLOR_RESET;
         near_limit   <= MIN_DIST_RESET;
         expected_hits.delete();
         errors = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_CENTRE_X:      sphere_cx    <= coord_type'(csr_wr_data);
               CSR_CENTRE_Y:      sphere_cy    <= coord_type'(csr_wr_data);
               CSR_CENTRE_Z:      sphere_cz    <= coord_type'(csr_wr_data);
               CSR_SPHERE_RADIUS: sphere_r     <= csr_wr_data[DIST_W-1:0];
               CSR_SURFACE_COLOR: sphere_color <= csr_wr_data[COLOR_W-1:0];
               CSR_MIN_DISTANCE:  near_limit   <= csr_wr_data[DIST_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            expected_hits.push_back(intersect_sphere(req.origin_x, req.origin_y,
               req.origin_z, req.dir_x, req.dir_y, req.dir_z, req.nearest_so_far));
         if (rsp.valid && rsp.ready) begin
            got.hit      = rsp.hit;
            got.distance = rsp.hit_distance;
            got.color    = rsp.hit_color;
            if (expected_hits.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected result hit=%0b dist=%h color=%h",
                           $realtime, got.hit, got.distance, got.color);
            end else begin
               want = expected_hits.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display({"%0t: mismatch exp hit=%0b dist=%h color=%h",
                               " got hit=%0b dist=%h color=%h"}, $realtime,
                              want.hit, want.distance, want.color,
                              got.hit, got.distance, got.color);
               end
            end
         end
      end
   end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import rsi_pkg::*;

   typedef struct {
      coord_type ox, oy, oz, dx, dy, dz;
      dist_type  limit;
   } ray_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int                    fail_count, pending;
   int                    results_seen = 0;
   int                    idle_pct;
   bit                    long_hold_done = 1'b0;

   rsi_req_if req_ch ();
   rsi_rsp_if rsp_ch ();

   ray_sphere_intersect i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   rsi_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #5_000_000;
      $display("ray_sphere_intersect regression: fail");
      $finish;
   end

   always @(posedge clock)
      if (!reset && rsp_ch.valid && rsp_ch.ready) results_seen++;

   function automatic int gap_len();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   // result side: random stalls plus one long hold-off to back up the pipe
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!long_hold_done && results_seen >= 150) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold_done = 1'b1;
            rsp_ch.ready <= 1'b1;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic wait_drained();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (110) @(posedge clock);
   endtask

   task automatic program_sphere(input coord_type cx, cy, cz, input dist_type r,
                                 input color_type col, input dist_type lim);
      logic [CSR_DATA_W-1:0] vals [6];
      vals = '{cx, cy, cz, r, col, lim};
      for (int i = 0; i < 6; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= CSR_IDX_W'(i);
         csr_wr_data <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_ray(input ray_t r);
      req_ch.valid          <= 1'b1;
      req_ch.origin_x       <= r.ox;
      req_ch.origin_y       <= r.oy;
      req_ch.origin_z       <= r.oz;
      req_ch.dir_x          <= r.dx;
      req_ch.dir_y          <= r.dy;
      req_ch.dir_z          <= r.dz;
      req_ch.nearest_so_far <= r.limit;
      do @(posedge clock); while (!req_ch.ready);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
   endtask

   function automatic ray_t make_ray(input coord_type cx, cy, cz, input bit aimed);
      ray_t r;
      longint k;
      if (!aimed) begin
         r = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               dist_type'($urandom)};
         return r;
      end
      // aim at the centre so the ray reaches it at about t = k, with jitter
      k    = $urandom_range(1, 200);
      r.dx = coord_type'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      r.dy = coord_type'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      r.dz = coord_type'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      r.ox = coord_type'(longint'(cx) - k * r.dx + $urandom_range(0, 1 << 17) - (1 << 16));
      r.oy = coord_type'(longint'(cy) - k * r.dy + $urandom_range(0, 1 << 17) - (1 << 16));
      r.oz = coord_type'(longint'(cz) - k * r.dz + $urandom_range(0, 1 << 17) - (1 << 16));
      case ($urandom_range(0, 3))
         0:       r.limit = '1;
         1:       r.limit = dist_type'($urandom);
         default: r.limit = dist_type'((k << 16) + $urandom_range(0, 1 << 18) - (1 << 17));
      endcase
      return r;
   endfunction

   task automatic random_phase(input coord_type cx, cy, cz, input dist_type r,
                               input color_type col, input dist_type lim,
                               input int count, input int idle);
      wait_drained();
      idle_pct = idle;
      program_sphere(cx, cy, cz, r, col, lim);
      for (int i = 0; i < count; i++) begin
         send_ray(make_ray(cx, cy, cz, $urandom_range(0, 99) < 75));
         // pause until everything sent so far has come back
         if (i == count / 2 && count > 60) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
      end
      req_ch.valid <= 1'b0;
   endtask

   initial begin
      ray_t directed [$];
      localparam coord_type ONE = 32'sd65536;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wr_data    = '0;
      req_ch.valid   = 1'b0;
      req_ch.origin_x = '0;
      req_ch.origin_y = '0;
      req_ch.origin_z = '0;
      req_ch.dir_x   = '0;
      req_ch.dir_y   = '0;
      req_ch.dir_z   = '0;
      req_ch.nearest_so_far = '0;
      idle_pct       = 20;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_sphere('0, '0, '0, dist_type'(1 << 16), 24'h123456, 31'd66);
      directed = '{
         '{-5 * ONE, 0, 0, ONE, 0, 0, '1},              // straight hit
         '{0, 0, 0, ONE, 0, 0, '1},                     // origin inside: far root
         '{-5 * ONE, ONE, 0, ONE, 0, 0, '1},            // tangent
         '{-5 * ONE, 0, 0, 0, 0, 0, '1},                // zero direction
         '{-5 * ONE, 0, 0, -ONE, 0, 0, '1},             // pointing away
         '{-5 * ONE, 2 * ONE, 0, ONE, 0, 0, '1},        // passes beside
         '{-5 * ONE, 0, 0, ONE, 0, 0, 31'd0},           // empty window
         '{-5 * ONE, 0, 0, ONE, 0, 0, 31'd66},          // window closed at minimum
         '{-5 * ONE, 0, 0, ONE, 0, 0, 31'(3 * ONE)},    // limit before sphere
         '{-5 * ONE, 0, 0, ONE, 0, 0, 31'(5 * ONE)},    // near root in window, far root past limit
         '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
           32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1},
         '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1},
         '{0, 0, 0, -1, -1, -1, '1},
         '{0, ONE / 2, 0, 0, 0, -ONE, 31'h5555_5555},
         '{0, 0, -3 * ONE, 0, 0, ONE / 4, 31'h2AAA_AAAA}
      };
      foreach (directed[i]) send_ray(directed[i]);
      req_ch.valid <= 1'b0;

      random_phase('0, '0, '0, dist_type'(1 << 16), 24'hFF_FFFF, 31'd66, 100, 20);
      random_phase(coord_type'(int'($urandom_range(0, 1 << 21)) - (1 << 20)),
                   coord_type'(int'($urandom_range(0, 1 << 21)) - (1 << 20)),
                   coord_type'(int'($urandom_range(0, 1 << 21)) - (1 << 20)),
                   dist_type'($urandom_range(1 << 12, 1 << 20)), color_type'($urandom),
                   dist_type'($urandom_range(0, 1 << 16)), 120, 30);
      random_phase(32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0, '0, 60, 20);
      random_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '1, 24'hFF_FFFF, '1,
                   50, 20);
      random_phase($urandom, $urandom, $urandom, dist_type'($urandom),
                   color_type'($urandom), dist_type'($urandom), 60, 20);
      random_phase('0, '0, '0, dist_type'($urandom_range(1 << 14, 1 << 18)),
                   color_type'($urandom), '0, 90, 0);
      random_phase(coord_type'(int'($urandom_range(0, 1 << 23)) - (1 << 22)), '0, '0,
                   dist_type'($urandom_range(1 << 16, 1 << 19)), 24'hA5_5A3C,
                   dist_type'($urandom_range(0, 200)), 70, 40);

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("ray_sphere_intersect regression: pass");
      else
         $display("ray_sphere_intersect regression: fail");
      $finish;
   end

endmodule
